// ===== rtl/lpht_pkg.sv =====
// Package for the linear-probe hash table: sizes, codes and shared types.
// No dependencies; used by every module of the block.
package lpht_pkg;

  localparam int TABLE_SIZE = 103;

  // Field widths fixed by the interface
  localparam int MODE_W     = 2;
  localparam int KEY_W      = 31;
  localparam int PAY_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 7;
  localparam int FREE_OUT_W = 7;

  // Derived from the table size
  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int FREE_W = $clog2(TABLE_SIZE + 1);

  // Home-slot unit: key modulo TABLE_SIZE by reciprocal multiplication.
  // A shift of KEY_W + ceil(log2 TABLE_SIZE) makes the quotient exact for
  // every key; only its low SLOT_W bits are kept.
  localparam int RECIP_SHIFT = KEY_W + SLOT_W;
  localparam int RECIP_W     = KEY_W + 1;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
  localparam int PROD_W      = RECIP_SHIFT + SLOT_W;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  // Result codes
  localparam logic [STATUS_W-1:0] RES_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] RES_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] RES_FULL    = 2'd2;

  // Slot state codes
  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_USED    = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    logic [1:0]       st;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            ent;
  } wr_req_t;

  typedef struct packed {
    logic   vld;
    entry_t ent;
  } rd_rsp_t;

endpackage

// ===== rtl/lpht_hash.sv =====
// Home-slot unit: key modulo TABLE_SIZE by reciprocal multiplication, then a registered correction.
// Depends on lpht_pkg.
module lpht_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [lpht_pkg::SLOT_W-1:0] rem
);
  import lpht_pkg::*;

  logic              step_r;
  logic              done_r;
  logic [SLOT_W-1:0] key_lo_r;
  logic [SLOT_W-1:0] quot_lo_r;
  logic [SLOT_W-1:0] rem_r;
  logic [SLOT_W-1:0] quot_lo;
  logic [SLOT_W-1:0] quot_mul;

  // Low quotient bits; product truncated to PROD_W keeps them exact
  assign quot_lo  = SLOT_W'((PROD_W'(key) * PROD_W'(RECIP_M)) >> RECIP_SHIFT);
  // key - q*TABLE_SIZE fits in SLOT_W bits, so low bits of both terms suffice
  assign quot_mul = quot_lo_r * SLOT_W'(TABLE_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= start;
      done_r <= step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_lo_r  <= key[SLOT_W-1:0];
      quot_lo_r <= quot_lo;
    end
    if (step_r) begin
      rem_r <= key_lo_r - quot_mul;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/lpht_store.sv =====
// Slot store: one synchronous memory of key, handle and slot state, plus
// per-slot valid bits so unwritten slots read as empty. Depends on lpht_pkg.
module lpht_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lpht_pkg::SLOT_W-1:0] rd_addr,
  input  lpht_pkg::wr_req_t           wr,
  output lpht_pkg::rd_rsp_t           rd
);
  import lpht_pkg::*;

  entry_t              mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld_r;
  entry_t              rd_ent_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.ent;
    end
    rd_ent_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
    end
  end

  assign rd.vld = rd_vld_r;
  assign rd.ent = rd_ent_r;

endmodule

// ===== rtl/linear_probe_hash_table_unit.sv =====
// Top level of the open-addressing hash table with linear probing.
// Depends on lpht_pkg, lpht_hash and lpht_store.
//
//  channel  | ports                                        | transfer when
//  ---------+----------------------------------------------+------------------
//  command  | start, busy, in_mode, in_order_key,          | start && !busy
//           | in_payload_in                                |
//  result   | out_valid, out_status, out_payload_out,      | out_valid (1 cycle)
//           | out_slot_index, out_free_slots               |
//
// Sequence: each operation probes 1 to TABLE_SIZE slots, and the next command
// is accepted only once the unit is idle again. The home slot comes from the
// modulo unit (reciprocal multiply, then a short correction); the probe walk
// then reads one slot per cycle through the single memory read port, the
// S_DONE state commits, and the result appears once the unit is idle again.
// Reset: synchronous, active low; all slots read as empty, free count is full.
// Stalls: none on the result side; out_valid is high for a single cycle.
module linear_probe_hash_table_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lpht_pkg::MODE_W-1:0]       in_mode,
  input  logic [lpht_pkg::KEY_W-1:0]        in_order_key,
  input  logic [lpht_pkg::PAY_W-1:0]        in_payload_in,
  output logic                              out_valid,
  output logic [lpht_pkg::STATUS_W-1:0]     out_status,
  output logic [lpht_pkg::PAY_W-1:0]        out_payload_out,
  output logic [lpht_pkg::SLOT_OUT_W-1:0]   out_slot_index,
  output logic [lpht_pkg::FREE_OUT_W-1:0]   out_free_slots
);
  import lpht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_PROBE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r;

  // Captured command
  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [PAY_W-1:0]  pay_r;

  // Probe walk
  logic [SLOT_W-1:0] idx_r;      // slot whose data arrives this cycle
  logic [SLOT_W-1:0] idx_next;
  logic [SLOT_W-1:0] n_r;        // slots already examined
  logic              found_r;
  logic [SLOT_W-1:0] hit_r;
  logic [PAY_W-1:0]  hit_pay_r;
  logic              ffree_ok_r; // first empty or deleted slot on the path
  logic [SLOT_W-1:0] ffree_r;

  logic [FREE_W-1:0] free_cnt_r;
  logic [FREE_W-1:0] free_nxt;

  // Result register
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [PAY_W-1:0]      out_pay_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [FREE_W-1:0]     out_free_r;

  logic [STATUS_W-1:0] res_status;
  logic [PAY_W-1:0]    res_pay;
  logic [SLOT_W-1:0]   res_slot;

  logic              accept;
  logic              hash_done;
  logic [SLOT_W-1:0] hash_rem;
  logic [SLOT_W-1:0] rd_addr;
  wr_req_t           wr;
  rd_rsp_t           rd;

  logic [1:0] cur_st;
  logic       cur_empty;
  logic       cur_hit;
  logic       cur_free;
  logic       last_probe;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  lpht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (in_order_key),
    .done  (hash_done),
    .rem   (hash_rem)
  );

  lpht_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  // Wrap-around step to the next slot
  assign idx_next = (idx_r == SLOT_W'(TABLE_SIZE - 1)) ? '0 : idx_r + 1'b1;

  // Read address runs one slot ahead of the evaluated data: the home slot is
  // issued as the modulo finishes, then each probe cycle issues the next slot.
  // Writes happen only in S_DONE and the next read is a full hash later, so
  // no read ever overlaps a pending write to the same slot.
  assign rd_addr = (state_r == S_HASH) ? hash_rem : idx_next;

  // Classify the slot under evaluation; never-written slots count as empty
  assign cur_st     = rd.vld ? rd.ent.st : SLOT_EMPTY;
  assign cur_empty  = (cur_st == SLOT_EMPTY);
  assign cur_hit    = (cur_st == SLOT_USED) && (rd.ent.key == key_r);
  assign cur_free   = (cur_st != SLOT_USED);
  assign last_probe = (n_r == SLOT_W'(TABLE_SIZE - 1));

  // Commit decision: write request, result fields, new free count
  always_comb begin
    wr         = '0;
    res_status = RES_MISSING;
    res_pay    = '0;
    res_slot   = '0;
    free_nxt   = free_cnt_r;
    if (state_r == S_DONE) begin
      priority if (mode_r == MODE_INSERT) begin
        if (found_r) begin
          // overwrite handle of a present key, free count unchanged
          wr.en      = 1'b1;
          wr.addr    = hit_r;
          wr.ent     = '{key: key_r, pay: pay_r, st: SLOT_USED};
          res_status = RES_DONE;
          res_pay    = pay_r;
          res_slot   = hit_r;
        end else if (ffree_ok_r) begin
          wr.en      = 1'b1;
          wr.addr    = ffree_r;
          wr.ent     = '{key: key_r, pay: pay_r, st: SLOT_USED};
          res_status = RES_DONE;
          res_pay    = pay_r;
          res_slot   = ffree_r;
          if (free_cnt_r != '0) begin
            free_nxt = free_cnt_r - 1'b1;
          end
        end else begin
          res_status = RES_FULL;
        end
      end else if (mode_r == MODE_DELETE) begin
        if (found_r) begin
          // tombstone keeps later probe chains intact
          wr.en      = 1'b1;
          wr.addr    = hit_r;
          wr.ent     = '{key: key_r, pay: hit_pay_r, st: SLOT_DELETED};
          res_status = RES_DONE;
          res_pay    = hit_pay_r;
          res_slot   = hit_r;
          if (free_cnt_r != FREE_W'(TABLE_SIZE)) begin
            free_nxt = free_cnt_r + 1'b1;
          end
        end
      end else begin
        // search, and the unused mode code behaves as a search
        if (found_r) begin
          res_status = RES_DONE;
          res_pay    = hit_pay_r;
          res_slot   = hit_r;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_cnt_r  <= FREE_W'(TABLE_SIZE);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state_r <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (cur_empty || cur_hit || last_probe) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          free_cnt_r  <= free_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      key_r  <= in_order_key;
      pay_r  <= in_payload_in;
    end
    if (state_r == S_HASH && hash_done) begin
      idx_r      <= hash_rem;
      n_r        <= '0;
      found_r    <= 1'b0;
      ffree_ok_r <= 1'b0;
    end
    if (state_r == S_PROBE) begin
      if (cur_free && !ffree_ok_r) begin
        ffree_ok_r <= 1'b1;
        ffree_r    <= idx_r;
      end
      if (cur_hit) begin
        found_r   <= 1'b1;
        hit_r     <= idx_r;
        hit_pay_r <= rd.ent.pay;
      end
      idx_r <= idx_next;
      n_r   <= n_r + 1'b1;
    end
    if (state_r == S_DONE) begin
      out_status_r <= res_status;
      out_pay_r    <= res_pay;
      out_slot_r   <= res_slot;
      out_free_r   <= free_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_payload_out = out_pay_r;
  assign out_slot_index  = SLOT_OUT_W'(out_slot_r);
  assign out_free_slots  = FREE_OUT_W'(out_free_r);

endmodule

// ===== rtl/lpht_checker.sv =====
// Port-level checker for the hash table top level, bound to it below.
// Depends on lpht_pkg and linear_probe_hash_table_unit.
module lpht_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [lpht_pkg::MODE_W-1:0]       in_mode,
  input logic [lpht_pkg::KEY_W-1:0]        in_order_key,
  input logic [lpht_pkg::PAY_W-1:0]        in_payload_in,
  input logic                              out_valid,
  input logic [lpht_pkg::STATUS_W-1:0]     out_status,
  input logic [lpht_pkg::PAY_W-1:0]        out_payload_out,
  input logic [lpht_pkg::SLOT_OUT_W-1:0]   out_slot_index,
  input logic [lpht_pkg::FREE_OUT_W-1:0]   out_free_slots
);
  import lpht_pkg::*;

  // a transfer in starts work that holds busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after command transfer");

  // the result is shown once the operation has ended
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // one result per operation
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // failed operations report zero handle and slot
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != RES_DONE) |->
      (out_payload_out == '0) && (out_slot_index == '0))
    else $error("nonzero fields on failed operation");

  // free count never exceeds the table and status is a known code
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_free_slots <= FREE_OUT_W'(TABLE_SIZE)) &&
      (out_status == RES_DONE || out_status == RES_MISSING || out_status == RES_FULL))
    else $error("free count or status out of range");

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (.*);
